// ----- rtl/core/stf_pkg.sv -----
// Shared types, constants and helpers for the shutter telegram framer.
// No dependencies.
`timescale 1ns / 1ps

package stf_pkg;

  localparam int unsigned TgBytes = 44;
  localparam int unsigned IdxW    = $clog2(TgBytes);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(TgBytes - 1);

  localparam logic [7:0] StxChar  = 8'h02;
  localparam logic [7:0] EtxChar  = 8'h03;
  localparam logic [7:0] ZeroChar = 8'h30;
  localparam logic [7:0] OneChar  = 8'h31;
  localparam logic [7:0] TwoChar  = 8'h32;
  localparam logic [7:0] BChar    = 8'h42;

  // Sum of the fixed payload bytes: 02, 01, 0B and the 21 after the unit code.
  localparam logic [7:0] FixedSum = 8'h2F;
  localparam logic [7:0] CksBase  = 8'h03;

  localparam logic [3:0] ChanBroadcast = 4'hF;

  typedef struct packed {
    logic [19:0] unit_code;
    logic [15:0] rolling_count;
    logic [3:0]  channel;
    logic [7:0]  command;
  } stf_in_t;

  typedef struct packed {
    logic [7:0] wire_byte;
    logic       last_byte;
    logic       bad_channel;
  } stf_out_t;

  // One held request with its precomputed checksum and channel check.
  typedef struct packed {
    stf_in_t    fields;
    logic [7:0] cks;
    logic       bad;
  } stf_req_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = ZeroChar + {4'h0, nib};
    end else begin
      c = 8'h37 + {4'h0, nib};
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/stf_req_stage.sv -----
// Request register: captures one command word, its checksum and channel check.
// Depends on stf_pkg.
`timescale 1ns / 1ps

module stf_req_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  stf_pkg::stf_in_t  in_data,
  input  logic              req_pop,
  output logic              req_vld,
  output stf_pkg::stf_req_t req
);
  import stf_pkg::*;

  logic       req_vld_r, req_vld_nxt;
  stf_req_t   req_r;
  logic       take;
  logic [7:0] sum;
  logic       bad;

  // Hold off new words while the held request still has bytes to send.
  assign in_stall = req_vld_r && !req_pop;
  assign take     = in_valid && !in_stall;

  always_comb begin
    sum = FixedSum
        + in_data.rolling_count[15:8]
        + in_data.rolling_count[7:0]
        + in_data.unit_code[19:12]
        + in_data.unit_code[11:4]
        + {in_data.unit_code[3:0], 4'h0}
        + {7'h00, (in_data.channel != 4'h0)}
        + {4'h0, in_data.channel}
        + in_data.command;
    bad = in_data.channel[3] && (in_data.channel != ChanBroadcast);
  end

  always_comb begin
    req_vld_nxt = req_vld_r;
    if (take) begin
      req_vld_nxt = 1'b1;
    end else if (req_pop) begin
      req_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else begin
      req_vld_r <= req_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_r.fields <= in_data;
      req_r.cks    <= CksBase - sum;
      req_r.bad    <= bad;
    end
  end

  assign req_vld = req_vld_r;
  assign req     = req_r;

endmodule

// ----- rtl/core/stf_byte_out.sv -----
// Byte sequencer: walks the telegram index and fills the output register.
// Depends on stf_pkg.
`timescale 1ns / 1ps

module stf_byte_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_vld,
  input  stf_pkg::stf_req_t req,
  output logic              req_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output stf_pkg::stf_out_t out_data
);
  import stf_pkg::*;

  logic [IdxW-1:0] idx_r, idx_nxt;
  logic            out_valid_r, out_valid_nxt;
  stf_out_t        out_data_r;
  logic            load;
  logic            last;
  logic [7:0]      tg_byte;

  assign load    = req_vld && (!out_valid_r || !out_stall);
  assign last    = req.bad || (idx_r == IdxLast);
  assign req_pop = load && last;

  always_comb begin
    case (idx_r) inside
      6'd0:                tg_byte = StxChar;
      [6'd1:6'd9], 6'd11, 6'd13, [6'd19:6'd24], 6'd30, 6'd33, 6'd35, 6'd37, 6'd38:
                           tg_byte = ZeroChar;
      6'd10, 6'd31:        tg_byte = TwoChar;
      6'd12, 6'd32:        tg_byte = OneChar;
      6'd14:               tg_byte = BChar;
      6'd15:               tg_byte = hex_char(req.fields.rolling_count[15:12]);
      6'd16:               tg_byte = hex_char(req.fields.rolling_count[11:8]);
      6'd17:               tg_byte = hex_char(req.fields.rolling_count[7:4]);
      6'd18:               tg_byte = hex_char(req.fields.rolling_count[3:0]);
      6'd25:               tg_byte = hex_char(req.fields.unit_code[19:16]);
      6'd26:               tg_byte = hex_char(req.fields.unit_code[15:12]);
      6'd27:               tg_byte = hex_char(req.fields.unit_code[11:8]);
      6'd28:               tg_byte = hex_char(req.fields.unit_code[7:4]);
      6'd29:               tg_byte = hex_char(req.fields.unit_code[3:0]);
      6'd34:               tg_byte = (req.fields.channel != 4'h0) ? OneChar : ZeroChar;
      6'd36:               tg_byte = hex_char(req.fields.channel);
      6'd39:               tg_byte = hex_char(req.fields.command[7:4]);
      6'd40:               tg_byte = hex_char(req.fields.command[3:0]);
      6'd41:               tg_byte = hex_char(req.cks[7:4]);
      6'd42:               tg_byte = hex_char(req.cks[3:0]);
      6'd43:               tg_byte = EtxChar;
      default:             tg_byte = 8'h00;
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = last ? '0 : idx_r + 1'b1;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.wire_byte   <= req.bad ? 8'h00 : tg_byte;
      out_data_r.last_byte   <= last;
      out_data_r.bad_channel <= req.bad;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/shutter_telegram_framer.sv -----
// Shutter telegram framer: one request word in, 44 telegram bytes out (one flagged byte for a bad channel).
// Path: the request word is held in the request register, and its first byte then passes the output register.
// Rate: one byte per cycle while the output is not stalled; a rejected word yields a single flagged byte.
// Reset (rst_n, synchronous, active low) empties the request and output registers.
// Depends on stf_pkg, stf_req_stage and stf_byte_out.
`timescale 1ns / 1ps

module shutter_telegram_framer (
  input  logic              clk,
  input  logic              rst_n,
  // request word
  input  logic              in_valid,
  output logic              in_stall,
  input  stf_pkg::stf_in_t  in_data,
  // telegram byte word
  output logic              out_valid,
  input  logic              out_stall,
  output stf_pkg::stf_out_t out_data
);
  import stf_pkg::*;

  logic     req_vld;
  logic     req_pop;
  stf_req_t req;

  // Capture the request; the checksum and channel check are settled here so
  // the byte sequencer only has to select one character per cycle.
  stf_req_stage u_req (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .req_pop  (req_pop),
    .req_vld  (req_vld),
    .req      (req)
  );

  // Advance through the telegram one byte per taken word; on the last byte
  // (or on a bad channel) release the request so the next word drops in
  // while the final byte still waits in the output register.
  stf_byte_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_vld   (req_vld),
    .req       (req),
    .req_pop   (req_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- tb/sv/shutter_telegram_framer_tb.sv -----
// Testbench for shutter_telegram_framer: directed and random request words, each
// telegram predicted byte by byte and checked in order at the byte port.
// Depends on stf_pkg and the framer RTL only.
`timescale 1ns / 1ps

module shutter_telegram_framer_tb;

  import stf_pkg::*;

  localparam int RandomWords = 440;
  localparam int QuietLimit  = 3000;  // cycles with no word moving on either port
  localparam int DrainCycles = 60;    // settle time after the last byte is due

  localparam logic [7:0] CmdHalt = 8'h10;
  localparam logic [7:0] CmdUp   = 8'h20;
  localparam logic [7:0] CmdDown = 8'h40;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  stf_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  stf_out_t out_data;

  // Request words waiting for the driver, and telegram bytes still owed by the framer.
  stf_in_t  request_q [$];
  stf_out_t telegram_q [$];

  // Idle rates in percent; the stimulus block switches them between phases.
  int send_idle_pct = 27;
  int recv_stall_pct = 48;

  int words_in = 0;
  int bad_words = 0;
  int bytes_out = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int total_words;

  shutter_telegram_framer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Telegram prediction
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + {4'h0, nib};
    end
    return 8'h41 + {4'h0, nib} - 8'd10;
  endfunction

  // Append one expected byte word to the tail of the owed queue.
  function automatic void owe_word(input stf_out_t o);
    telegram_q = {telegram_q, o};
  endfunction

  function automatic void owe_byte(input logic [7:0] b, input logic last);
    stf_out_t o;
    o.wire_byte   = b;
    o.last_byte   = last;
    o.bad_channel = 1'b0;
    owe_word(o);
  endfunction

  // Append one request word to the tail of the driver queue.
  function automatic void queue_request(input stf_in_t w);
    request_q = {request_q, w};
  endfunction

  // Queue every byte the framer owes for one accepted request word.
  function automatic void frame_telegram(input stf_in_t req);
    logic [7:0] pay [20];
    logic [7:0] cks;
    stf_out_t   reject;
    if (!(req.channel <= 4'd7 || req.channel == ChanBroadcast)) begin
      // Channels 8 to 14: one flagged byte, no telegram at all.
      reject.wire_byte   = 8'h00;
      reject.last_byte   = 1'b1;
      reject.bad_channel = 1'b1;
      owe_word(reject);
      return;
    end
    // The 40 hex characters read as 20 byte pairs. The unit code is five
    // digits, so its last digit pairs with the leading 0 of the "021" field.
    pay = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h01, 8'h0B,
            req.rolling_count[15:8], req.rolling_count[7:0],
            8'h00, 8'h00, 8'h00,
            req.unit_code[19:12], req.unit_code[11:4], {req.unit_code[3:0], 4'h0},
            8'h21,
            (req.channel == 4'd0) ? 8'h00 : 8'h01,
            {4'h0, req.channel},
            8'h00,
            req.command};
    cks = CksBase;
    owe_byte(StxChar, 1'b0);
    for (int k = 0; k < 20; k++) begin
      cks = cks - pay[k];
      owe_byte(ascii_hex(pay[k][7:4]), 1'b0);
      owe_byte(ascii_hex(pay[k][3:0]), 1'b0);
    end
    owe_byte(ascii_hex(cks[7:4]), 1'b0);
    owe_byte(ascii_hex(cks[3:0]), 1'b0);
    owe_byte(EtxChar, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present the next request word, hold it while stalled
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      // The current word (if any) moves this edge; load the next or idle.
      if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= request_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each accepted request, check each accepted byte
  // ---------------------------------------------------------------------------

  // Prediction and checking share one process so a byte can never be checked
  // ahead of the request that owes it.
  always @(posedge clk) begin
    stf_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        frame_telegram(in_data);
        words_in = words_in + 1;
        if (!(in_data.channel <= 4'd7 || in_data.channel == ChanBroadcast)) begin
          bad_words = bad_words + 1;
        end
      end
      if (out_valid && !out_stall) begin
        bytes_out = bytes_out + 1;
        if (telegram_q.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("%0t: unexpected byte %h last=%b bad=%b", $realtime,
                     out_data.wire_byte, out_data.last_byte, out_data.bad_channel);
          end
        end else begin
          want = telegram_q.pop_front();
          if (out_data.wire_byte !== want.wire_byte || out_data.last_byte !== want.last_byte ||
              out_data.bad_channel !== want.bad_channel) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) begin
              $display("%0t: byte %0d mismatch: want %h last=%b bad=%b, got %h last=%b bad=%b",
                       $realtime, bytes_out, want.wire_byte, want.last_byte, want.bad_channel,
                       out_data.wire_byte, out_data.last_byte, out_data.bad_channel);
            end
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: give up when neither port moves a word for too long
  // ---------------------------------------------------------------------------

  // Bytes nobody is waiting for do not count as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) ||
        (out_valid && !out_stall && telegram_q.size() != 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("timeout: no word moved for %0d cycles, %0d bytes still owed",
               QuietLimit, telegram_q.size());
      $display("shutter_telegram_framer_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, idle phases and end of run
  // ---------------------------------------------------------------------------

  initial begin
    stf_in_t    req;
    int         r;
    logic [7:0] cmd_set [5];
    cmd_set = '{CmdHalt, CmdUp, CmdDown, 8'h00, 8'hFF};

    // Directed: every channel value, field extremes, every command in the set.
    for (int ch = 0; ch < 16; ch++) begin
      req.unit_code     = (ch % 3 == 0) ? 20'h00000 : (ch % 3 == 1) ? 20'hFFFFF : 20'hA5C3E;
      req.rolling_count = (ch % 2 == 1) ? 16'hFFFF : 16'h0000;
      req.channel       = 4'(ch);
      req.command       = cmd_set[ch % 5];
      queue_request(req);
    end
    // All-ones payload drives the checksum through several wraps.
    queue_request('{20'hFFFFF, 16'hFFFF, ChanBroadcast, 8'hFF});
    queue_request('{20'h00000, 16'h0000, 4'd0, 8'h00});
    queue_request('{20'h12345, 16'h6789, 4'd7, CmdDown});
    queue_request('{20'hFEDCB, 16'hA987, 4'd1, CmdUp});

    // Random: mostly well-formed requests, some bad channels and odd commands.
    for (int n = 0; n < RandomWords; n++) begin
      r = $urandom_range(99);
      if (r < 12) begin
        req.channel = 4'($urandom_range(14, 8));
      end else if (r < 20) begin
        req.channel = ChanBroadcast;
      end else if (r < 28) begin
        req.channel = 4'd0;
      end else begin
        req.channel = 4'($urandom_range(7, 1));
      end
      if ($urandom_range(99) < 60) begin
        req.command = cmd_set[$urandom_range(2)];
      end else begin
        req.command = 8'($urandom);
      end
      r = $urandom_range(19);
      req.unit_code     = (r == 0) ? 20'h00000 : (r == 1) ? 20'hFFFFF : 20'($urandom);
      r = $urandom_range(19);
      req.rolling_count = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
      queue_request(req);
    end
    total_words = request_q.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Swap the idle rates after a third of the words, then stop idling.
    while (words_in < total_words / 3) @(negedge clk);
    send_idle_pct  = 48;
    recv_stall_pct = 27;
    while (words_in < 2 * total_words / 3) @(negedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    while (words_in < total_words || telegram_q.size() != 0) @(negedge clk);
    // Hold a little longer to catch stray bytes after the last telegram.
    repeat (DrainCycles) @(negedge clk);
    if (telegram_q.size() != 0) begin
      mismatches = mismatches + telegram_q.size();
      $display("%0d bytes never arrived", telegram_q.size());
    end

    $display("%0d request words (%0d with a bad channel), %0d bytes checked, %0d mismatches",
             words_in, bad_words, bytes_out, mismatches);
    $display("idle phases: sender 27/receiver 48, sender 48/receiver 27, then none");
    if (mismatches == 0) begin
      $display("shutter_telegram_framer_tb OK");
    end else begin
      $display("shutter_telegram_framer_tb NOT OK");
    end
    $finish;
  end

endmodule
